// ===== rtl/ohash_pkg.sv =====
// Package: shared types, constants and helper functions for the hash table.
package ohash_pkg;

    localparam int CAPACITY_DEF    = 1024;
    localparam int KEY_WIDTH_DEF   = 32;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int HASH_W          = 32;
    localparam int CNT_W           = $clog2(HASH_W);
    localparam int LG_W            = 5;
    localparam int TS_W            = 11;
    localparam int OP_W            = 3;
    localparam int STATUS_W        = 2;
    localparam int FIFO_DEPTH      = 2;
    localparam logic [TS_W-1:0] TS_RESET = 11'd1021;
    localparam int TS_MIN          = 3;

    typedef enum logic [OP_W-1:0] {
        OP_LOOKUP = 3'd0,
        OP_INSERT = 3'd1,
        OP_SET    = 3'd2,
        OP_DELETE = 3'd3,
        OP_CLEAR  = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_EMPTY = 2'd0,
        ST_TOMB  = 2'd1,
        ST_FULL  = 2'd2
    } slot_st_t;

    typedef enum logic [STATUS_W-1:0] {
        RES_OK       = 2'd0,
        RES_NOTFOUND = 2'd1,
        RES_FULL     = 2'd2
    } res_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } front_st_t;

    typedef enum logic [2:0] {
        B_SWEEP,
        B_IDLE,
        B_READ,
        B_EVAL
    } back_st_t;

    function automatic logic [LG_W-1:0] floor_log2(input logic [31:0] x);
        logic [LG_W-1:0] r;
        r = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (x[i])
            begin
                r = LG_W'(i);
            end
        end
        return r;
    endfunction

endpackage

// ===== rtl/ohash_front.sv =====
// Front end: accepts items and computes probe start and stride by bit-serial modulo.
module ohash_front #(
    parameter int CAPACITY    = ohash_pkg::CAPACITY_DEF,
    parameter int KEY_WIDTH   = ohash_pkg::KEY_WIDTH_DEF,
    parameter int VALUE_WIDTH = ohash_pkg::VALUE_WIDTH_DEF,
    localparam int IDX_W      = $clog2(CAPACITY),
    localparam int SZ_W       = IDX_W + 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [ohash_pkg::OP_W-1:0]   operation,
    input  logic [KEY_WIDTH-1:0]         key,
    input  logic [ohash_pkg::HASH_W-1:0] key_hash,
    input  logic [VALUE_WIDTH-1:0]       value,
    input  logic [SZ_W-1:0]              size,
    input  logic [ohash_pkg::LG_W-1:0]   lg,
    output logic                         push_valid,
    input  logic                         push_ready,
    output logic [ohash_pkg::OP_W-1:0]   p_op,
    output logic [KEY_WIDTH-1:0]         p_key,
    output logic [VALUE_WIDTH-1:0]       p_val,
    output logic [IDX_W-1:0]             p_start,
    output logic [IDX_W-1:0]             p_step
);

    ohash_pkg::front_st_t state_reg, state_next;
    logic [ohash_pkg::CNT_W-1:0]  cnt_reg;
    logic [ohash_pkg::HASH_W-1:0] hash_reg;
    logic [SZ_W-1:0]              rem_s_reg;
    logic [ohash_pkg::LG_W-1:0]   rem_l_reg;
    logic [ohash_pkg::OP_W-1:0]   op_reg;
    logic [KEY_WIDTH-1:0]         key_reg;
    logic [VALUE_WIDTH-1:0]       val_reg;
    logic [SZ_W:0]                ts;
    logic [ohash_pkg::LG_W:0]     tl;
    logic [SZ_W-1:0]              rem_s_next;
    logic [ohash_pkg::LG_W-1:0]   rem_l_next;

    always_comb
    begin
        ts = {rem_s_reg, hash_reg[ohash_pkg::HASH_W-1]};
        tl = {rem_l_reg, hash_reg[ohash_pkg::HASH_W-1]};
        rem_s_next = (ts >= {1'b0, size}) ? SZ_W'(ts - {1'b0, size}) : SZ_W'(ts);
        rem_l_next = (tl >= {1'b0, lg}) ? ohash_pkg::LG_W'(tl - {1'b0, lg})
                                        : ohash_pkg::LG_W'(tl);
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        push_valid = 1'b0;
        case (state_reg)
            ohash_pkg::F_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = ohash_pkg::F_DIV;
                end
            end
            ohash_pkg::F_DIV:
            begin
                if (cnt_reg == ohash_pkg::CNT_W'(ohash_pkg::HASH_W - 1))
                begin
                    state_next = ohash_pkg::F_PUSH;
                end
            end
            ohash_pkg::F_PUSH:
            begin
                push_valid = 1'b1;
                if (push_ready)
                begin
                    state_next = ohash_pkg::F_IDLE;
                end
            end
            default:
            begin
                state_next = ohash_pkg::F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ohash_pkg::F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ohash_pkg::F_IDLE && in_valid)
        begin
            op_reg    <= operation;
            key_reg   <= key;
            val_reg   <= value;
            hash_reg  <= key_hash;
            rem_s_reg <= '0;
            rem_l_reg <= '0;
            cnt_reg   <= '0;
        end
        else if (state_reg == ohash_pkg::F_DIV)
        begin
            rem_s_reg <= rem_s_next;
            rem_l_reg <= rem_l_next;
            hash_reg  <= {hash_reg[ohash_pkg::HASH_W-2:0], 1'b0};
            cnt_reg   <= cnt_reg + 1'b1;
        end
    end

    assign p_op    = op_reg;
    assign p_key   = key_reg;
    assign p_val   = val_reg;
    assign p_start = rem_s_reg[IDX_W-1:0];
    assign p_step  = IDX_W'(SZ_W'(1) << rem_l_reg);

endmodule

// ===== rtl/ohash_fifo.sv =====
// Small queue between front end and probe engine.
module ohash_fifo #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr_valid,
    output logic         wr_ready,
    input  logic [W-1:0] wr_data,
    output logic         rd_valid,
    input  logic         rd_ready,
    output logic [W-1:0] rd_data
);

    localparam int PTR_W = $clog2(ohash_pkg::FIFO_DEPTH);

    logic [W-1:0]     mem_reg [ohash_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0] wp_reg, rp_reg;
    logic [PTR_W:0]   cnt_reg;
    logic             do_wr, do_rd;

    assign wr_ready = (cnt_reg != (PTR_W+1)'(ohash_pkg::FIFO_DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;
    assign rd_data  = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (do_rd)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

endmodule

// ===== rtl/ohash_back.sv =====
// Probe engine: slot memories, probe sequencer, clearing sweep and result register.
module ohash_back #(
    parameter int CAPACITY    = ohash_pkg::CAPACITY_DEF,
    parameter int KEY_WIDTH   = ohash_pkg::KEY_WIDTH_DEF,
    parameter int VALUE_WIDTH = ohash_pkg::VALUE_WIDTH_DEF,
    localparam int IDX_W      = $clog2(CAPACITY),
    localparam int SZ_W       = IDX_W + 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [SZ_W-1:0]                size,
    input  logic                           pop_valid,
    output logic                           pop_ready,
    input  logic [ohash_pkg::OP_W-1:0]     q_op,
    input  logic [KEY_WIDTH-1:0]           q_key,
    input  logic [VALUE_WIDTH-1:0]         q_val,
    input  logic [IDX_W-1:0]               q_start,
    input  logic [IDX_W-1:0]               q_step,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [ohash_pkg::STATUS_W-1:0] status,
    output logic                           found,
    output logic [IDX_W-1:0]               slot_index,
    output logic [VALUE_WIDTH-1:0]         value_out
);

    logic [1:0]             st_mem  [CAPACITY];
    logic [KEY_WIDTH-1:0]   key_mem [CAPACITY];
    logic [VALUE_WIDTH-1:0] val_mem [CAPACITY];

    ohash_pkg::back_st_t state_reg, state_next;
    logic [ohash_pkg::OP_W-1:0] op_reg;
    logic [KEY_WIDTH-1:0]       key_reg;
    logic [VALUE_WIDTH-1:0]     val_reg;
    logic [IDX_W-1:0]           idx_reg, idx_next;
    logic [IDX_W-1:0]           step_reg;
    logic [IDX_W-1:0]           cnt_reg, cnt_next;
    logic                       free_ok_reg, free_ok_next;
    logic [IDX_W-1:0]           free_idx_reg, free_idx_next;
    logic [IDX_W-1:0]           sweep_reg, sweep_next;
    logic                       clr_reg, clr_next;

    logic [1:0]             st_rd;
    logic [KEY_WIDTH-1:0]   key_rd;
    logic [VALUE_WIDTH-1:0] val_rd;

    logic                             out_valid_reg, out_valid_next;
    logic [ohash_pkg::STATUS_W-1:0]   status_reg, status_next;
    logic                             found_reg, found_next;
    logic [IDX_W-1:0]                 sidx_reg, sidx_next;
    logic [VALUE_WIDTH-1:0]           vout_reg, vout_next;

    logic                   st_we, key_we, val_we;
    logic [IDX_W-1:0]       waddr;
    logic [1:0]             st_wd;

    logic                   is_full, is_empty, is_match, is_last;
    logic [SZ_W-1:0]        sum;
    logic [IDX_W-1:0]       adv_idx;
    logic                   cand_ok;
    logic [IDX_W-1:0]       cand_idx;

    always_comb
    begin
        is_full  = (st_rd == ohash_pkg::ST_FULL);
        is_empty = (st_rd == ohash_pkg::ST_EMPTY);
        is_match = is_full && (key_rd == key_reg);
        is_last  = ({1'b0, cnt_reg} == size - 1'b1);
        sum      = {1'b0, idx_reg} + {1'b0, step_reg};
        adv_idx  = (sum >= size) ? IDX_W'(sum - size) : IDX_W'(sum);
        cand_ok  = free_ok_reg || !is_full;
        cand_idx = free_ok_reg ? free_idx_reg : idx_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        free_ok_next   = free_ok_reg;
        free_idx_next  = free_idx_reg;
        sweep_next     = sweep_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        found_next     = found_reg;
        sidx_next      = sidx_reg;
        vout_next      = vout_reg;
        pop_ready      = 1'b0;
        st_we          = 1'b0;
        key_we         = 1'b0;
        val_we         = 1'b0;
        waddr          = idx_reg;
        st_wd          = ohash_pkg::ST_FULL;
        case (state_reg)
            ohash_pkg::B_SWEEP:
            begin
                st_we      = 1'b1;
                waddr      = sweep_reg;
                st_wd      = ohash_pkg::ST_EMPTY;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == IDX_W'(CAPACITY - 1))
                begin
                    state_next = ohash_pkg::B_IDLE;
                    if (clr_reg)
                    begin
                        out_valid_next = 1'b1;
                        status_next    = ohash_pkg::RES_OK;
                        found_next     = 1'b0;
                        sidx_next      = '0;
                        vout_next      = '0;
                    end
                end
            end
            ohash_pkg::B_IDLE:
            begin
                pop_ready = !out_valid_reg;
                if (pop_valid && !out_valid_reg)
                begin
                    idx_next     = q_start;
                    cnt_next     = '0;
                    free_ok_next = 1'b0;
                    case (q_op)
                        ohash_pkg::OP_LOOKUP, ohash_pkg::OP_INSERT,
                        ohash_pkg::OP_SET, ohash_pkg::OP_DELETE:
                        begin
                            state_next = ohash_pkg::B_READ;
                        end
                        ohash_pkg::OP_CLEAR:
                        begin
                            state_next = ohash_pkg::B_SWEEP;
                            sweep_next = '0;
                            clr_next   = 1'b1;
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                            status_next    = ohash_pkg::RES_OK;
                            found_next     = 1'b0;
                            sidx_next      = '0;
                            vout_next      = '0;
                        end
                    endcase
                end
            end
            ohash_pkg::B_READ:
            begin
                state_next = ohash_pkg::B_EVAL;
            end
            ohash_pkg::B_EVAL:
            begin
                status_next = ohash_pkg::RES_OK;
                found_next  = 1'b0;
                sidx_next   = '0;
                vout_next   = '0;
                state_next  = ohash_pkg::B_IDLE;
                if (op_reg == ohash_pkg::OP_INSERT)
                begin
                    if (!is_full)
                    begin
                        st_we = 1'b1;
                        key_we = 1'b1;
                        val_we = 1'b1;
                        sidx_next = idx_reg;
                        out_valid_next = 1'b1;
                    end
                    else if (is_last)
                    begin
                        status_next = ohash_pkg::RES_FULL;
                        out_valid_next = 1'b1;
                    end
                    else
                    begin
                        idx_next = adv_idx;
                        cnt_next = cnt_reg + 1'b1;
                        state_next = ohash_pkg::B_READ;
                    end
                end
                else if (is_match)
                begin
                    found_next = 1'b1;
                    sidx_next = idx_reg;
                    out_valid_next = 1'b1;
                    if (op_reg == ohash_pkg::OP_LOOKUP)
                    begin
                        vout_next = val_rd;
                    end
                    else if (op_reg == ohash_pkg::OP_DELETE)
                    begin
                        st_we = 1'b1;
                        st_wd = ohash_pkg::ST_TOMB;
                    end
                    else
                    begin
                        val_we = 1'b1;
                    end
                end
                else if (is_empty || is_last)
                begin
                    out_valid_next = 1'b1;
                    if (op_reg == ohash_pkg::OP_SET)
                    begin
                        if (cand_ok)
                        begin
                            waddr = cand_idx;
                            st_we = 1'b1;
                            key_we = 1'b1;
                            val_we = 1'b1;
                            sidx_next = cand_idx;
                        end
                        else
                        begin
                            status_next = ohash_pkg::RES_FULL;
                        end
                    end
                    else
                    begin
                        status_next = ohash_pkg::RES_NOTFOUND;
                    end
                end
                else
                begin
                    if (!is_full && !free_ok_reg)
                    begin
                        free_ok_next = 1'b1;
                        free_idx_next = idx_reg;
                    end
                    idx_next = adv_idx;
                    cnt_next = cnt_reg + 1'b1;
                    state_next = ohash_pkg::B_READ;
                end
            end
            default:
            begin
                state_next = ohash_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ohash_pkg::B_SWEEP;
            sweep_reg     <= '0;
            clr_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop_valid && pop_ready)
        begin
            op_reg   <= q_op;
            key_reg  <= q_key;
            val_reg  <= q_val;
            step_reg <= q_step;
        end
        idx_reg      <= idx_next;
        cnt_reg      <= cnt_next;
        free_ok_reg  <= free_ok_next;
        free_idx_reg <= free_idx_next;
        status_reg   <= status_next;
        found_reg    <= found_next;
        sidx_reg     <= sidx_next;
        vout_reg     <= vout_next;
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            st_mem[waddr] <= st_wd;
        end
        if (key_we)
        begin
            key_mem[waddr] <= key_reg;
        end
        if (val_we)
        begin
            val_mem[waddr] <= val_reg;
        end
        st_rd  <= st_mem[idx_reg];
        key_rd <= key_mem[idx_reg];
        val_rd <= val_mem[idx_reg];
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign found      = found_reg;
    assign slot_index = sidx_reg;
    assign value_out  = vout_reg;

    a_no_pop_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ohash_pkg::B_SWEEP) |-> !pop_ready)
        else $error("item taken during sweep");

    a_hit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && found_reg) |-> ({1'b0, sidx_reg} < size))
        else $error("hit slot beyond table size");

    a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == ohash_pkg::RES_FULL) |-> (sidx_reg == '0 && !found_reg))
        else $error("table-full result carries slot data");

endmodule

// ===== rtl/open_addressing_hash_table.sv =====
// Top level: open-addressing hash table with tombstones, config register and APB port.
// Front end, per item: accept state, bit-serial modulo over the hash bits, then push state (bit-serial divider).
// Probe engine: each probed slot takes a registered memory read, then an evaluate step.
// Clear sweeps all CAPACITY slots to empty, then gives its result.
// Front and engine overlap: the front end can take a new item while the engine probes the last.
// Reset: a clearing pass empties all CAPACITY slots; the probe engine takes no item meanwhile.
module open_addressing_hash_table #(
    parameter int CAPACITY    = ohash_pkg::CAPACITY_DEF,
    parameter int KEY_WIDTH   = ohash_pkg::KEY_WIDTH_DEF,
    parameter int VALUE_WIDTH = ohash_pkg::VALUE_WIDTH_DEF,
    localparam int IDX_W      = $clog2(CAPACITY),
    localparam int SZ_W       = IDX_W + 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [2:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [ohash_pkg::OP_W-1:0]     operation,
    input  logic [KEY_WIDTH-1:0]           key,
    input  logic [ohash_pkg::HASH_W-1:0]   key_hash,
    input  logic [VALUE_WIDTH-1:0]         value,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [ohash_pkg::STATUS_W-1:0] status,
    output logic                           found,
    output logic [IDX_W-1:0]               slot_index,
    output logic [VALUE_WIDTH-1:0]         value_out
);

    localparam int QW = ohash_pkg::OP_W + KEY_WIDTH + VALUE_WIDTH + 2 * IDX_W;

    logic [ohash_pkg::TS_W-1:0] table_size_reg;
    logic [31:0]                ts32;
    logic [SZ_W-1:0]            size;
    logic [ohash_pkg::LG_W-1:0] lg;

    logic                       push_valid, push_ready, pop_valid, pop_ready;
    logic [ohash_pkg::OP_W-1:0] p_op, q_op;
    logic [KEY_WIDTH-1:0]       p_key, q_key;
    logic [VALUE_WIDTH-1:0]     p_val, q_val;
    logic [IDX_W-1:0]           p_start, p_step, q_start, q_step;
    logic [QW-1:0]              q_data;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? 32'(table_size_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg <= ohash_pkg::TS_RESET;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == 1'b0)
        begin
            table_size_reg <= pwdata[ohash_pkg::TS_W-1:0];
        end
    end

    always_comb
    begin
        ts32 = 32'(table_size_reg);
        if (ts32 < 32'(ohash_pkg::TS_MIN))
        begin
            size = SZ_W'(ohash_pkg::TS_MIN);
        end
        else if (ts32 > 32'(CAPACITY))
        begin
            size = SZ_W'(CAPACITY);
        end
        else
        begin
            size = SZ_W'(ts32);
        end
        lg = ohash_pkg::floor_log2(32'(size));
    end

    ohash_front #(
        .CAPACITY(CAPACITY), .KEY_WIDTH(KEY_WIDTH), .VALUE_WIDTH(VALUE_WIDTH)
    ) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .operation(operation), .key(key), .key_hash(key_hash), .value(value),
        .size(size), .lg(lg),
        .push_valid(push_valid), .push_ready(push_ready),
        .p_op(p_op), .p_key(p_key), .p_val(p_val), .p_start(p_start), .p_step(p_step)
    );

    ohash_fifo #(.W(QW)) u_fifo (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(push_valid), .wr_ready(push_ready),
        .wr_data({p_op, p_key, p_val, p_start, p_step}),
        .rd_valid(pop_valid), .rd_ready(pop_ready),
        .rd_data(q_data)
    );

    assign {q_op, q_key, q_val, q_start, q_step} = q_data;

    ohash_back #(
        .CAPACITY(CAPACITY), .KEY_WIDTH(KEY_WIDTH), .VALUE_WIDTH(VALUE_WIDTH)
    ) u_back (
        .clk(clk), .rst_n(rst_n), .size(size),
        .pop_valid(pop_valid), .pop_ready(pop_ready),
        .q_op(q_op), .q_key(q_key), .q_val(q_val), .q_start(q_start), .q_step(q_step),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .found(found), .slot_index(slot_index), .value_out(value_out)
    );

endmodule
